FILE: rtl/core/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and constants for the button press duration classifier.
// ----------------------------------------------------------------------------
package bpd_pkg;

    // width of the elapsed tick counter (legal range 8 to 32)
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic [CMP_WIDTH-1:0]   cmp_t;
    typedef logic [2:0]             click_class_t;

    // result classes
    localparam click_class_t CLASS_NONE  = 3'd0;
    localparam click_class_t CLASS_SHORT = 3'd1;
    localparam click_class_t CLASS_TWO   = 3'd2;
    localparam click_class_t CLASS_FOUR  = 3'd3;
    localparam click_class_t CLASS_EIGHT = 3'd4;

    // register indexes
    localparam cfg_idx_t REG_DEBOUNCE   = 4'd0;
    localparam cfg_idx_t REG_SHORT_MAX  = 4'd1;
    localparam cfg_idx_t REG_TWO_LOW    = 4'd2;
    localparam cfg_idx_t REG_TWO_HIGH   = 4'd3;
    localparam cfg_idx_t REG_FOUR_LOW   = 4'd4;
    localparam cfg_idx_t REG_FOUR_HIGH  = 4'd5;
    localparam cfg_idx_t REG_EIGHT_LOW  = 4'd6;
    localparam cfg_idx_t REG_EIGHT_HIGH = 4'd7;

    // register reset values
    localparam cfg_word_t RST_DEBOUNCE   = 16'd100;
    localparam cfg_word_t RST_SHORT_MAX  = 16'd500;
    localparam cfg_word_t RST_TWO_LOW    = 16'd2000;
    localparam cfg_word_t RST_TWO_HIGH   = 16'd3000;
    localparam cfg_word_t RST_FOUR_LOW   = 16'd4000;
    localparam cfg_word_t RST_FOUR_HIGH  = 16'd6000;
    localparam cfg_word_t RST_EIGHT_LOW  = 16'd8000;
    localparam cfg_word_t RST_EIGHT_HIGH = 16'd12000;

    typedef struct packed {
        logic edge_seen;
        logic pin_state;
    } bpd_in_t;

    typedef struct packed {
        click_class_t click_class;
        logic         held;
        logic         debouncing;
    } bpd_out_t;

endpackage

FILE: rtl/core/button_press_duration_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier_core
// Debounce and long press classifier for one button, one tick per beat.
// ----------------------------------------------------------------------------
// usage:
//   in channel   : one beat per time tick, carrying edge_seen and pin_state
//   out channel  : exactly one beat per tick: click_class (nonzero only on a
//                  release), plus the held and debouncing flags after the tick
//   cfg channel  : register index and 16-bit data, always ready; write only
//                  while no tick is in flight; indexes above seven are dropped
// each result beat is registered and appears in the cycle after its input beat.
// throughput is one tick per cycle unless the output stalls: the state update
// is a saturating counter and a handful of threshold compares between the
// state registers and the result register. the result register doubles as the
// output buffer, so a new tick is taken whenever the buffer is empty or is
// being drained in the same cycle. while the receiver stalls with a result
// waiting, the input is held off and the buffered result stays put.
// reset clears the state flags, the counter and the output valid, and loads
// the default thresholds into the configuration registers.
// ----------------------------------------------------------------------------
module button_press_duration_classifier_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpd_pkg::bpd_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bpd_pkg::bpd_out_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bpd_pkg::cfg_idx_t   cfg_index,
    input  bpd_pkg::cfg_word_t  cfg_data
);

    bpd_pkg::cfg_word_t debounce_reg;
    bpd_pkg::cfg_word_t short_max_reg;
    bpd_pkg::cfg_word_t two_low_reg;
    bpd_pkg::cfg_word_t two_high_reg;
    bpd_pkg::cfg_word_t four_low_reg;
    bpd_pkg::cfg_word_t four_high_reg;
    bpd_pkg::cfg_word_t eight_low_reg;
    bpd_pkg::cfg_word_t eight_high_reg;

    logic               pending_reg, pending_next;
    logic               held_reg, held_next;
    bpd_pkg::count_t    elapsed_reg, elapsed_next;
    logic               out_valid_reg;
    bpd_pkg::bpd_out_t  out_data_reg, out_data_next;

    logic               accept;
    logic               start, fire, release_hit;
    logic               pend_a, held_a;
    bpd_pkg::count_t    cnt_inc, cnt_a, cnt_b;
    bpd_pkg::cmp_t      dur;
    bpd_pkg::click_class_t cls;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bpd_pkg::RST_DEBOUNCE;
            short_max_reg  <= bpd_pkg::RST_SHORT_MAX;
            two_low_reg    <= bpd_pkg::RST_TWO_LOW;
            two_high_reg   <= bpd_pkg::RST_TWO_HIGH;
            four_low_reg   <= bpd_pkg::RST_FOUR_LOW;
            four_high_reg  <= bpd_pkg::RST_FOUR_HIGH;
            eight_low_reg  <= bpd_pkg::RST_EIGHT_LOW;
            eight_high_reg <= bpd_pkg::RST_EIGHT_HIGH;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpd_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                bpd_pkg::REG_SHORT_MAX:  short_max_reg  <= cfg_data;
                bpd_pkg::REG_TWO_LOW:    two_low_reg    <= cfg_data;
                bpd_pkg::REG_TWO_HIGH:   two_high_reg   <= cfg_data;
                bpd_pkg::REG_FOUR_LOW:   four_low_reg   <= cfg_data;
                bpd_pkg::REG_FOUR_HIGH:  four_high_reg  <= cfg_data;
                bpd_pkg::REG_EIGHT_LOW:  eight_low_reg  <= cfg_data;
                bpd_pkg::REG_EIGHT_HIGH: eight_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // saturating tick count
        cnt_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

        // edge starts a debounce unless one is already running
        start  = in_data.edge_seen && !pending_reg;
        cnt_a  = start ? '0 : cnt_inc;
        pend_a = pending_reg || start;

        fire = pend_a &&
               (bpd_pkg::cmp_t'(cnt_a) > bpd_pkg::cmp_t'(debounce_reg));
        cnt_b        = (fire && in_data.pin_state) ? '0 : cnt_a;
        held_a       = held_reg || (fire && in_data.pin_state);
        pending_next = pend_a && !fire;

        release_hit = held_a && !in_data.pin_state;
        dur = bpd_pkg::cmp_t'(cnt_b);

        priority if (dur <= bpd_pkg::cmp_t'(short_max_reg))
            cls = bpd_pkg::CLASS_SHORT;
        else if (dur > bpd_pkg::cmp_t'(two_low_reg) &&
                 dur <= bpd_pkg::cmp_t'(two_high_reg))
            cls = bpd_pkg::CLASS_TWO;
        else if (dur > bpd_pkg::cmp_t'(four_low_reg) &&
                 dur <= bpd_pkg::cmp_t'(four_high_reg))
            cls = bpd_pkg::CLASS_FOUR;
        else if (dur > bpd_pkg::cmp_t'(eight_low_reg) &&
                 dur <= bpd_pkg::cmp_t'(eight_high_reg))
            cls = bpd_pkg::CLASS_EIGHT;
        else
            cls = bpd_pkg::CLASS_NONE;

        held_next    = held_a && !release_hit;
        elapsed_next = release_hit ? '0 : cnt_b;

        out_data_next.click_class = release_hit ? cls : bpd_pkg::CLASS_NONE;
        out_data_next.held        = held_next;
        out_data_next.debouncing  = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            held_reg      <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pending_reg <= pending_next;
                held_reg    <= held_next;
                elapsed_reg <= elapsed_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/core/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks for the button press duration classifier.
// ----------------------------------------------------------------------------
module bpd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bpd_pkg::bpd_out_t   out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // every accepted tick shows a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick gave no result");

    // class code stays in its legal range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.click_class <= bpd_pkg::CLASS_EIGHT)
        else $error("illegal click class");

    // a release ends the held press
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.click_class != bpd_pkg::CLASS_NONE |-> !out_data.held)
        else $error("classed release still held");

endmodule

bind button_press_duration_classifier_core bpd_checker u_bpd_checker (.*);
